[rtl/core/crsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsd_pkg
// Shared types and constants for the column run-length sprite decoder.
// ----------------------------------------------------------------------------
package crsd_pkg;

    localparam int DIM_W   = 11;
    localparam int ADDR_W  = 20;
    localparam int PIX_W   = 8;
    localparam int RUN_W   = 7;
    localparam int LANE_W  = 3;

    localparam logic [DIM_W-1:0] MAX_DIM = 11'd1024;
    localparam int OUT_LANES    = 4;
    localparam int HEADER_BYTES = 24;
    localparam int LANES_CLAMP  = (OUT_LANES < 1) ? 1 : ((OUT_LANES > 4) ? 4 : OUT_LANES);
    localparam logic [LANE_W-1:0] LANES_EFF = LANE_W'(LANES_CLAMP);

    // split point between literal-count and zero-run control bytes
    localparam logic [PIX_W-1:0] CTRL_SPLIT = 8'd128;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // input request kinds
    localparam logic REQ_OFFSET = 1'b0;
    localparam logic REQ_DATA   = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_CELL_WIDTH  = 2'd0;
    localparam logic [1:0] REG_CELL_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COMP_MODE   = 2'd2;
    localparam logic [1:0] REG_DATA_SIZE   = 2'd3;

    typedef struct packed {
        logic [DIM_W-1:0]  cell_width;
        logic [DIM_W-1:0]  cell_height;
        logic              compressed_mode;
        logic [ADDR_W-1:0] data_size;
    } cfg_t;

    // one decoded command: a span of total pixels starting at addr, emitted
    // lanes at a time; flags apply to the final result of the span
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
        logic [RUN_W-1:0]  total;
        logic [LANE_W-1:0] lanes;
        logic              done;
        logic              stop;
        logic              ovr;
    } cmd_t;

endpackage

[rtl/core/crsd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsd_queue
// Small command FIFO between the decode front and the output back end.
// ----------------------------------------------------------------------------
module crsd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  crsd_pkg::cmd_t push_cmd,
    input  logic           pop,
    output crsd_pkg::cmd_t head,
    output logic           full,
    output logic           empty
);
    import crsd_pkg::*;

    cmd_t               mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[rtl/core/crsd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsd_front
// Accepts requests, tracks column/row state and turns each request into at
// most one command for the back end.
// ----------------------------------------------------------------------------
module crsd_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  crsd_pkg::cfg_t              cfg,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic signed [31:0]          s_column_offset,
    input  logic [crsd_pkg::PIX_W-1:0]  s_data_byte,
    input  logic                        q_full,
    output logic                        push,
    output crsd_pkg::cmd_t              push_cmd
);
    import crsd_pkg::*;

    logic [DIM_W-1:0]  column_index_reg, column_index_next;
    logic [DIM_W-1:0]  row_index_reg, row_index_next;
    logic [ADDR_W-1:0] column_base_reg, column_base_next;
    logic [PIX_W-1:0]  literal_left_reg, literal_left_next;
    logic              in_column_reg, in_column_next;
    logic              halted_reg, halted_next;
    logic [ADDR_W-1:0] raw_addr_reg, raw_addr_next;

    logic              accept;
    logic [DIM_W:0]    row_inc;
    logic [DIM_W:0]    rows_left;
    logic              left_neg;
    logic              lit_over;
    logic [RUN_W-1:0]  run_k;
    logic              run_over;
    logic [RUN_W-1:0]  run_len;
    logic [RUN_W:0]    need_sum;
    logic [LANE_W-1:0] run_need;
    logic [LANE_W-1:0] run_lanes;
    logic [DIM_W:0]    row_run;
    logic [ADDR_W-1:0] pix_addr;
    logic [33:0]       off_s;
    logic              off_bad;
    logic [2*DIM_W-1:0] base_prod;
    logic              col_ok;
    logic [DIM_W:0]    height_x;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;

    assign height_x  = {1'b0, cfg.cell_height};
    assign row_inc   = {1'b0, row_index_reg} + 12'd1;
    assign rows_left = height_x - {1'b0, row_index_reg};
    assign left_neg  = rows_left[DIM_W];
    assign lit_over  = !left_neg && ({4'd0, s_data_byte} > rows_left);
    assign run_k     = s_data_byte[RUN_W-1:0];
    assign run_over  = !left_neg && ({5'd0, run_k} > rows_left);
    assign run_len   = run_over ? rows_left[RUN_W-1:0] : run_k;
    // results per run capped at 32: lanes raised to ceil(k/32) where needed
    assign need_sum  = {1'b0, run_k} + 8'd31;
    assign run_need  = need_sum[RUN_W:5];
    assign run_lanes = (run_need > LANES_EFF) ? run_need : LANES_EFF;
    assign row_run   = {1'b0, row_index_reg} + {5'd0, run_len};
    assign pix_addr  = column_base_reg + {9'd0, row_index_reg};
    assign off_s     = {{2{s_column_offset[31]}}, s_column_offset} - 34'(HEADER_BYTES);
    assign off_bad   = off_s[33] || (off_s >= {14'd0, cfg.data_size});
    assign base_prod = {11'd0, column_index_reg} * {11'd0, cfg.cell_height};
    assign col_ok    = column_index_reg < cfg.cell_width;

    always_comb begin
        column_index_next = column_index_reg;
        row_index_next    = row_index_reg;
        column_base_next  = column_base_reg;
        literal_left_next = literal_left_reg;
        in_column_next    = in_column_reg;
        halted_next       = halted_reg;
        raw_addr_next     = raw_addr_reg;
        push              = 1'b0;
        push_cmd          = '0;
        push_cmd.lanes    = 3'd1;

        if (accept) begin
            if (!cfg.compressed_mode) begin
                if (s_req_type == REQ_DATA && cfg.cell_height != '0 && col_ok) begin
                    push           = 1'b1;
                    push_cmd.addr  = raw_addr_reg;
                    push_cmd.pix   = s_data_byte;
                    push_cmd.total = 7'd1;
                    raw_addr_next  = raw_addr_reg + 1'b1;
                    if (row_inc >= height_x) begin
                        push_cmd.done     = 1'b1;
                        row_index_next    = '0;
                        column_index_next = column_index_reg + 1'b1;
                    end else begin
                        row_index_next = row_inc[DIM_W-1:0];
                    end
                end
            end else if (!halted_reg) begin
                if (s_req_type == REQ_OFFSET) begin
                    if (col_ok) begin
                        if (off_bad) begin
                            halted_next    = 1'b1;
                            in_column_next = 1'b0;
                            push           = 1'b1;
                            push_cmd.stop  = 1'b1;
                        end else begin
                            column_base_next  = base_prod[ADDR_W-1:0];
                            row_index_next    = '0;
                            literal_left_next = '0;
                            if (cfg.cell_height == '0) begin
                                // empty column completes at once
                                in_column_next    = 1'b0;
                                column_index_next = column_index_reg + 1'b1;
                                push              = 1'b1;
                                push_cmd.done     = 1'b1;
                            end else begin
                                in_column_next = 1'b1;
                            end
                        end
                    end
                end else if (in_column_reg) begin
                    if (literal_left_reg != '0) begin
                        push              = 1'b1;
                        push_cmd.addr     = pix_addr;
                        push_cmd.pix      = s_data_byte;
                        push_cmd.total    = 7'd1;
                        literal_left_next = literal_left_reg - 1'b1;
                        row_index_next    = row_inc[DIM_W-1:0];
                        if (row_inc >= height_x) begin
                            push_cmd.done     = 1'b1;
                            in_column_next    = 1'b0;
                            row_index_next    = '0;
                            literal_left_next = '0;
                            column_index_next = column_index_reg + 1'b1;
                        end
                    end else if (s_data_byte <= CTRL_SPLIT) begin
                        if (lit_over) begin
                            literal_left_next = rows_left[PIX_W-1:0];
                            push              = 1'b1;
                            push_cmd.ovr      = 1'b1;
                        end else begin
                            literal_left_next = s_data_byte;
                        end
                    end else if (run_len != '0) begin
                        push           = 1'b1;
                        push_cmd.addr  = pix_addr;
                        push_cmd.total = run_len;
                        push_cmd.lanes = run_lanes;
                        push_cmd.ovr   = run_over;
                        row_index_next = row_run[DIM_W-1:0];
                        if (row_run >= height_x) begin
                            push_cmd.done     = 1'b1;
                            in_column_next    = 1'b0;
                            row_index_next    = '0;
                            literal_left_next = '0;
                            column_index_next = column_index_reg + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_index_reg <= '0;
            row_index_reg    <= '0;
            column_base_reg  <= '0;
            literal_left_reg <= '0;
            in_column_reg    <= 1'b0;
            halted_reg       <= 1'b0;
            raw_addr_reg     <= '0;
        end else begin
            column_index_reg <= column_index_next;
            row_index_reg    <= row_index_next;
            column_base_reg  <= column_base_next;
            literal_left_reg <= literal_left_next;
            in_column_reg    <= in_column_next;
            halted_reg       <= halted_next;
            raw_addr_reg     <= raw_addr_next;
        end
    end

endmodule

[rtl/core/crsd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsd_back
// Expands queued commands into result requests, up to the command's lane
// count per result, through a registered output stage.
// ----------------------------------------------------------------------------
module crsd_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         q_empty,
    input  crsd_pkg::cmd_t               head,
    output logic                         pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [crsd_pkg::ADDR_W-1:0]  m_pixel_addr,
    output logic [crsd_pkg::PIX_W-1:0]   m_pixel_a,
    output logic [crsd_pkg::PIX_W-1:0]   m_pixel_b,
    output logic [crsd_pkg::PIX_W-1:0]   m_pixel_c,
    output logic [crsd_pkg::PIX_W-1:0]   m_pixel_d,
    output logic [2:0]                   m_pixel_count,
    output logic                         m_column_done,
    output logic                         m_stopped,
    output logic                         m_overrun,
    output logic                         m_last
);
    import crsd_pkg::*;

    logic [RUN_W-1:0]  sent_reg, sent_next;
    logic              valid_reg, valid_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [PIX_W-1:0]  pix_reg, pix_next;
    logic [2:0]        count_reg, count_next;
    logic              done_reg, done_next;
    logic              stop_reg, stop_next;
    logic              ovr_reg, ovr_next;
    logic              last_reg, last_next;

    logic [RUN_W-1:0]  remaining;
    logic              last_chunk;
    logic [LANE_W-1:0] chunk;
    logic              slot_free;
    logic              emit;

    assign remaining  = head.total - sent_reg;
    assign last_chunk = remaining <= {4'd0, head.lanes};
    assign chunk      = last_chunk ? remaining[LANE_W-1:0] : head.lanes;
    assign slot_free  = !valid_reg || m_ready;
    assign emit       = slot_free && !q_empty;
    assign pop        = emit && last_chunk;

    always_comb begin
        sent_next  = sent_reg;
        valid_next = valid_reg;
        addr_next  = addr_reg;
        pix_next   = pix_reg;
        count_next = count_reg;
        done_next  = done_reg;
        stop_next  = stop_reg;
        ovr_next   = ovr_reg;
        last_next  = last_reg;
        if (emit) begin
            valid_next = 1'b1;
            count_next = chunk;
            addr_next  = (chunk != '0) ? head.addr + {13'd0, sent_reg} : '0;
            pix_next   = (chunk != '0) ? head.pix : '0;
            done_next  = last_chunk && head.done;
            stop_next  = last_chunk && head.stop;
            ovr_next   = last_chunk && head.ovr;
            last_next  = last_chunk;
            sent_next  = last_chunk ? '0 : sent_reg + {4'd0, chunk};
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sent_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            sent_reg  <= sent_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg  <= addr_next;
        pix_reg   <= pix_next;
        count_reg <= count_next;
        done_reg  <= done_next;
        stop_reg  <= stop_next;
        ovr_reg   <= ovr_next;
        last_reg  <= last_next;
    end

    assign m_valid       = valid_reg;
    assign m_pixel_addr  = addr_reg;
    assign m_pixel_a     = pix_reg;
    // only zero runs carry more than one pixel, so the upper lanes are zero
    assign m_pixel_b     = '0;
    assign m_pixel_c     = '0;
    assign m_pixel_d     = '0;
    assign m_pixel_count = count_reg;
    assign m_column_done = done_reg;
    assign m_stopped     = stop_reg;
    assign m_overrun     = ovr_reg;
    assign m_last        = last_reg;

    a_empty_result_final: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && count_reg == 3'd0 |-> addr_reg == '0 && last_reg)
        else $error("empty result with address or not final");

    a_flags_only_on_final: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !last_reg |-> !done_reg && !stop_reg && !ovr_reg)
        else $error("status flag on a non-final result");

    a_run_keeps_head: assert property (@(posedge aclk) disable iff (!aresetn)
        sent_reg != '0 |-> !q_empty)
        else $error("partial run with empty queue");

    a_split_run_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && count_reg > 3'd1 |-> pix_reg == '0)
        else $error("multi-pixel result with nonzero pixel");

endmodule

[rtl/core/column_rle_sprite_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_rle_sprite_decoder
// Path: a request's command is queued, then its result leaves the output register.
// Throughput: one request per cycle while the 4-entry command queue has room;
// a zero run of k pixels is split into results of up to lanes pixels each.
// Reset: synchronous active-low aresetn clears decode state, queue and output
// valid; configuration returns to width 1, height 1, raw mode, size 0.
// ----------------------------------------------------------------------------
module column_rle_sprite_decoder (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [crsd_pkg::ADDR_W-1:0]  cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_req_type,
    input  logic signed [31:0]           s_column_offset,
    input  logic [crsd_pkg::PIX_W-1:0]   s_data_byte,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [crsd_pkg::ADDR_W-1:0]  m_pixel_addr,
    output logic [crsd_pkg::PIX_W-1:0]   m_pixel_a,
    output logic [crsd_pkg::PIX_W-1:0]   m_pixel_b,
    output logic [crsd_pkg::PIX_W-1:0]   m_pixel_c,
    output logic [crsd_pkg::PIX_W-1:0]   m_pixel_d,
    output logic [2:0]                   m_pixel_count,
    output logic                         m_column_done,
    output logic                         m_stopped,
    output logic                         m_overrun,
    output logic                         m_last
);
    import crsd_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic [DIM_W-1:0] dim_in;
    logic [DIM_W-1:0] dim_sat;

    logic q_full, q_empty, push, pop;
    cmd_t push_cmd, head;

    assign cfg_ready = 1'b1;
    assign dim_in    = cfg_data[DIM_W-1:0];
    assign dim_sat   = (dim_in > MAX_DIM) ? MAX_DIM : dim_in;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_CELL_WIDTH:  cfg_next.cell_width      = dim_sat;
                REG_CELL_HEIGHT: cfg_next.cell_height     = dim_sat;
                REG_COMP_MODE:   cfg_next.compressed_mode = cfg_data[0];
                REG_DATA_SIZE:   cfg_next.data_size       = cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cell_width      <= 11'd1;
            cfg_reg.cell_height     <= 11'd1;
            cfg_reg.compressed_mode <= 1'b0;
            cfg_reg.data_size       <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    crsd_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_column_offset (s_column_offset),
        .s_data_byte     (s_data_byte),
        .q_full          (q_full),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    crsd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    crsd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .head          (head),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_addr  (m_pixel_addr),
        .m_pixel_a     (m_pixel_a),
        .m_pixel_b     (m_pixel_b),
        .m_pixel_c     (m_pixel_c),
        .m_pixel_d     (m_pixel_d),
        .m_pixel_count (m_pixel_count),
        .m_column_done (m_column_done),
        .m_stopped     (m_stopped),
        .m_overrun     (m_overrun),
        .m_last        (m_last)
    );

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the column run-length sprite decoder. A scoreboard
// class predicts every pixel result from the requests the block accepts and
// checks each result in order. The stimulus opens with directed raw and coded
// cells, then runs random well-formed columns mixed with noise, covering clipped
// runs, column restarts, zero height and a final bad offset that halts
// decoding. Both channels stall at random, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    import crsd_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_ITEMS  = 430;
    localparam int MAX_REPORTS   = 20;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix_a;
        logic [PIX_W-1:0]  pix_b;
        logic [PIX_W-1:0]  pix_c;
        logic [PIX_W-1:0]  pix_d;
        logic [2:0]        count;
        logic              done;
        logic              stop;
        logic              ovr;
        logic              last;
    } pix_result_t;

    class pixel_scoreboard;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic              comp;
        logic [ADDR_W-1:0] dsize;
        logic [DIM_W-1:0]  col_idx;
        logic [DIM_W-1:0]  row_idx;
        logic [ADDR_W-1:0] col_base;
        logic [ADDR_W-1:0] raw_addr;
        logic [7:0]        lit_left;
        logic              in_col;
        logic              halted;
        pix_result_t       pending_pixels[$];
        int                errors;
        int                checked;
        int                cols_closed;
        int                overruns;
        int                halts;

        function new();
            width = 1;
            height = 1;
            comp = 0;
            dsize = 0;
            col_idx = 0;
            row_idx = 0;
            col_base = 0;
            raw_addr = 0;
            lit_left = 0;
            in_col = 0;
            halted = 0;
            errors = 0;
            checked = 0;
            cols_closed = 0;
            overruns = 0;
            halts = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [ADDR_W-1:0] val);
            case (idx)
                REG_CELL_WIDTH:  width  = (val[DIM_W-1:0] > MAX_DIM) ? MAX_DIM : val[DIM_W-1:0];
                REG_CELL_HEIGHT: height = (val[DIM_W-1:0] > MAX_DIM) ? MAX_DIM : val[DIM_W-1:0];
                REG_COMP_MODE:   comp   = val[0];
                REG_DATA_SIZE:   dsize  = val;
                default: ;
            endcase
        endfunction

        function pix_result_t span(logic [ADDR_W-1:0] addr, int unsigned cnt);
            pix_result_t r;
            r = '0;
            r.count = cnt[2:0];
            if (cnt != 0) r.addr = addr;
            return r;
        endfunction

        function void queue_result(pix_result_t r);
            pending_pixels.insert(pending_pixels.size(), r);
        endfunction

        function void close_column();
            in_col = 0;
            row_idx = 0;
            lit_left = 0;
            col_idx = col_idx + 1'b1;
            cols_closed++;
        endfunction

        // returns 0 when the request is dropped without touching any state
        function bit decode_request(logic rt, logic signed [31:0] off, logic [PIX_W-1:0] b);
            pix_result_t r;
            longint      rel;
            int unsigned left;
            int unsigned run;
            int unsigned lanes;
            int unsigned c;
            int          n;
            logic        ovr;
            if (!comp) begin
                if (rt == REQ_OFFSET || height == 0 || col_idx >= width) return 0;
                r = span(raw_addr, 1);
                r.pix_a = b;
                r.last = 1;
                raw_addr = raw_addr + 1'b1;
                row_idx = row_idx + 1'b1;
                if (row_idx >= height) begin
                    r.done = 1;
                    row_idx = 0;
                    col_idx = col_idx + 1'b1;
                    cols_closed++;
                end
                queue_result(r);
                return 1;
            end
            if (halted) return 0;
            if (rt == REQ_OFFSET) begin
                if (col_idx >= width) return 0;
                rel = longint'(off) - HEADER_BYTES;
                if (rel < 0 || rel >= longint'(dsize)) begin
                    halted = 1;
                    in_col = 0;
                    r = span(0, 0);
                    r.stop = 1;
                    r.last = 1;
                    halts++;
                    queue_result(r);
                    return 1;
                end
                col_base = ADDR_W'(32'(col_idx) * 32'(height));
                row_idx = 0;
                lit_left = 0;
                if (height == 0) begin
                    close_column();
                    r = span(0, 0);
                    r.done = 1;
                    r.last = 1;
                    queue_result(r);
                    return 1;
                end
                in_col = 1;
                return 1;
            end
            if (!in_col) return 0;

            left = 32'(height) - 32'(row_idx);
            if (lit_left != 0) begin
                r = span(col_base + ADDR_W'(row_idx), 1);
                r.pix_a = b;
                r.last = 1;
                lit_left = lit_left - 1'b1;
                row_idx = row_idx + 1'b1;
                if (row_idx >= height) begin
                    close_column();
                    r.done = 1;
                end
                queue_result(r);
                return 1;
            end
            if (b <= CTRL_SPLIT) begin
                if (32'(b) > left) begin
                    // literal count past the column end: clipped, flagged once
                    lit_left = 8'(left);
                    r = span(0, 0);
                    r.ovr = 1;
                    r.last = 1;
                    overruns++;
                    queue_result(r);
                    return 1;
                end
                lit_left = b;
                return 1;
            end

            run = 32'(b) - 32'(CTRL_SPLIT);
            lanes = LANES_CLAMP;
            if (lanes < (run + 31) / 32) lanes = (run + 31) / 32;
            ovr = 0;
            if (run > left) begin
                run = left;
                ovr = 1;
            end
            n = 0;
            while (run > 0 && n < 32) begin
                c = (run < lanes) ? run : lanes;
                r = span(col_base + ADDR_W'(row_idx), c);
                row_idx = row_idx + DIM_W'(c);
                run = run - c;
                n++;
                if (run == 0 || n == 32) begin
                    r.ovr = ovr;
                    r.last = 1;
                    if (ovr) overruns++;
                    if (row_idx >= height) begin
                        close_column();
                        r.done = 1;
                    end
                end
                queue_result(r);
            end
            return 1;
        endfunction

        function string show(pix_result_t r);
            return $sformatf({"addr=%05h pix=%02h,%02h,%02h,%02h n=%0d ",
                              "done=%b stop=%b ovr=%b last=%b"},
                r.addr, r.pix_a, r.pix_b, r.pix_c, r.pix_d, r.count,
                r.done, r.stop, r.ovr, r.last);
        endfunction

        function void check_result(pix_result_t got);
            pix_result_t want;
            if (pending_pixels.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual %s",
                        $time, show(got));
                return;
            end
            want = pending_pixels.pop_front();
            checked++;
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result differs, expected %s, actual %s",
                        $time, show(want), show(got));
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_index;
    logic [ADDR_W-1:0]    cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_req_type;
    logic signed [31:0]   s_column_offset;
    logic [PIX_W-1:0]     s_data_byte;
    logic                 m_valid;
    logic                 m_ready;
    logic [ADDR_W-1:0]    m_pixel_addr;
    logic [PIX_W-1:0]     m_pixel_a;
    logic [PIX_W-1:0]     m_pixel_b;
    logic [PIX_W-1:0]     m_pixel_c;
    logic [PIX_W-1:0]     m_pixel_d;
    logic [2:0]           m_pixel_count;
    logic                 m_column_done;
    logic                 m_stopped;
    logic                 m_overrun;
    logic                 m_last;

    pixel_scoreboard sb;
    pix_result_t     seen;
    int              n_sent;
    int              n_useful;
    int              send_idle_pct;
    int              recv_idle_pct;
    bit              hold_request;
    int              hold_left;
    int              cycles;

    column_rle_sprite_decoder i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_column_offset (s_column_offset),
        .s_data_byte     (s_data_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_addr    (m_pixel_addr),
        .m_pixel_a       (m_pixel_a),
        .m_pixel_b       (m_pixel_b),
        .m_pixel_c       (m_pixel_c),
        .m_pixel_d       (m_pixel_d),
        .m_pixel_count   (m_pixel_count),
        .m_column_done   (m_column_done),
        .m_stopped       (m_stopped),
        .m_overrun       (m_overrun),
        .m_last          (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time,
                sb.pending_pixels.size());
            $display("column_rle_sprite_decoder: mismatch");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        bit hold_taken;
        m_ready = 1'b0;
        hold_left = 0;
        hold_taken = 0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_taken) begin
                hold_left = HOLD_CYCLES;
                hold_taken = 1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen = {m_pixel_addr, m_pixel_a, m_pixel_b, m_pixel_c, m_pixel_d,
                    m_pixel_count, m_column_done, m_stopped, m_overrun, m_last};
            sb.check_result(seen);
        end
    end

    task automatic send_request(input logic rt, input logic signed [31:0] off,
                                input logic [PIX_W-1:0] b);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= rt;
        s_column_offset <= off;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
        if (sb.decode_request(rt, off, b)) n_useful++;
    endtask

    task automatic send_data(input logic [PIX_W-1:0] b);
        send_request(REQ_DATA, $urandom(), b);
    endtask

    task automatic send_offset(input logic signed [31:0] off);
        send_request(REQ_OFFSET, off, 8'($urandom()));
    endtask

    // drop the request line and wait until every predicted result is out
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [ADDR_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_cell(input logic mode, input logic [ADDR_W-1:0] w,
                             input logic [ADDR_W-1:0] h, input logic [ADDR_W-1:0] size);
        cfg_write(REG_CELL_WIDTH, w);
        cfg_write(REG_CELL_HEIGHT, h);
        cfg_write(REG_COMP_MODE, {19'($urandom()), mode});
        cfg_write(REG_DATA_SIZE, size);
    endtask

    task automatic pick_idle();
        if (n_useful < RANDOM_ITEMS / 3) begin
            send_idle_pct = 37;
            recv_idle_pct = 70;
        end else if (n_useful < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 70;
            recv_idle_pct = 37;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    function automatic logic [ADDR_W-1:0] pick_width();
        int unsigned w;
        w = $urandom_range(32'(sb.col_idx) + 1, 1024);
        case ($urandom_range(0, 5))
            0: return 20'hFFFFF;
            1: return 20'd1024;
            default: return {9'($urandom()), 11'(w)};
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pick_height(int unsigned hi);
        int unsigned h;
        h = $urandom_range(2, hi);
        case ($urandom_range(0, 9))
            0: h = 1;
            1: h = 0;
            default: ;
        endcase
        return {9'($urandom()), 11'(h)};
    endfunction

    function automatic logic signed [31:0] good_offset();
        case ($urandom_range(0, 7))
            0: return HEADER_BYTES;
            1: return HEADER_BYTES + 32'(sb.dsize) - 1;
            default: return HEADER_BYTES + $urandom_range(0, 32'(sb.dsize) - 1);
        endcase
    endfunction

    // one coded column: mostly clean runs, with clipped runs, empty control
    // bytes, stray bytes and restarts mixed in
    task automatic emit_column();
        int unsigned left;
        int unsigned cnt;
        int unsigned k;
        if ($urandom_range(0, 7) == 0) send_data(8'($urandom()));
        send_offset(good_offset());
        if (sb.in_col && $urandom_range(0, 9) == 0) begin
            send_data(8'd130);
            send_offset(good_offset());
        end
        while (sb.in_col) begin
            left = 32'(sb.height) - 32'(sb.row_idx);
            case ($urandom_range(0, 19))
                0: send_data(8'd0);
                1: begin
                    if (left < 128) begin
                        send_data(8'($urandom_range(left + 1, 128)));
                        while (sb.in_col) send_data(8'($urandom()));
                        repeat ($urandom_range(0, 2)) send_data(8'($urandom()));
                    end
                end
                2: begin
                    if (left < 127) send_data(8'(128 + $urandom_range(left + 1, 127)));
                end
                3, 4, 5, 6, 7, 8, 9, 10: begin
                    cnt = $urandom_range(1, (left < 8) ? left : 8);
                    if ($urandom_range(0, 7) == 0) cnt = (left < 128) ? left : 128;
                    send_data(8'(cnt));
                    for (k = 0; k < cnt && sb.in_col; k++) send_data(8'($urandom()));
                end
                default: send_data(8'(128 + $urandom_range(1, (left < 127) ? left : 127)));
            endcase
        end
    endtask

    initial begin
        int               kind;
        int               ncols;
        int               i;
        bit               big_done;
        bit               pressure_done;
        logic signed [31:0] bad;

        sb = new();
        cycles = 0;
        n_sent = 0;
        n_useful = 0;
        hold_request = 0;
        big_done = 0;
        pressure_done = 0;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_valid = 1'b0;
        s_req_type = 1'b0;
        s_column_offset = '0;
        s_data_byte = '0;
        send_idle_pct = 37;
        recv_idle_pct = 70;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset cell is one pixel: the second byte falls outside it
        send_data(8'h5A);
        send_data(8'hC3);
        settle();
        load_cell(1'b0, 20'hFFFFF, 20'd2, 20'd0);
        send_data(8'h00);
        send_offset($urandom());
        send_data(8'hFF);
        settle();
        load_cell(1'b1, 20'hFFFFF, 20'd8, 20'd100);
        send_offset(HEADER_BYTES);
        send_data(8'd0);
        send_data(8'd2);
        send_data(8'hFF);
        send_data(8'h00);
        send_data(8'd129);
        send_data(8'd131);
        send_data(8'd128);      // literal run past the column end
        send_data(8'h11);
        send_data(8'h22);
        send_data(8'h33);       // surplus literal, no column open
        send_offset(HEADER_BYTES + 99);
        send_data(8'd255);      // zero run clipped at the height
        send_offset(50);
        send_data(8'd130);
        send_offset(60);        // restart inside the column
        send_data(8'd136);
        settle();
        load_cell(1'b1, 20'hFFFFF, 20'h00800, 20'd100);
        send_offset(30);

        n_useful = 0;
        while (n_useful < RANDOM_ITEMS && sb.col_idx < 980) begin
            settle();
            pick_idle();
            kind = $urandom_range(0, 9);
            if (!pressure_done && n_useful >= 40) kind = 5;
            if (!big_done && n_useful >= 200) kind = 6;
            case (kind)
                0, 1: begin
                    load_cell(1'b0, pick_width(), {9'($urandom()), 11'($urandom_range(1, 6))},
                              20'($urandom()));
                    repeat ($urandom_range(8, 30)) begin
                        if ($urandom_range(0, 7) == 0) send_offset($urandom());
                        else send_data(8'($urandom()));
                    end
                end
                9: begin
                    // every column already used: all of this is dropped
                    load_cell(1'($urandom()), {9'($urandom()), sb.col_idx},
                              pick_height(20), 20'($urandom()));
                    repeat (6) send_request(1'($urandom()), $urandom(), 8'($urandom()));
                end
                default: begin
                    case ($urandom_range(0, 7))
                        0: bad = 1;
                        1: bad = 32'hFFFFF;
                        default: bad = $urandom_range(1, 20'hFFFFF);
                    endcase
                    if (kind == 6 && !big_done) begin
                        big_done = 1;
                        load_cell(1'b1, 20'd1024, 20'h007FF, 20'(bad));
                        ncols = 1;
                    end else if (kind == 5 && !pressure_done) begin
                        // tall enough that two columns overfill the queue
                        load_cell(1'b1, 20'd1024, 20'd16, 20'(bad));
                        ncols = 1;
                    end else begin
                        load_cell(1'b1, pick_width(), pick_height(24), 20'(bad));
                        ncols = $urandom_range(1, 4);
                    end
                    if (kind == 5 && !pressure_done) begin
                        pressure_done = 1;
                        hold_request = 1;
                        emit_column();
                        emit_column();
                        settle();   // hold new requests until the block drains
                    end
                    for (i = 0; i < ncols; i++) emit_column();
                end
            endcase
        end

        // a bad offset halts coded decoding for good; raw mode still runs
        settle();
        load_cell(1'b1, 20'd1024, 20'($urandom_range(1, 8)), 20'($urandom_range(1, 200)));
        emit_column();
        case ($urandom_range(0, 2))
            0: bad = {1'b1, 31'($urandom())};
            1: bad = $urandom_range(0, HEADER_BYTES - 1);
            default: bad = HEADER_BYTES + 32'(sb.dsize) + $urandom_range(0, 32'h7000_0000);
        endcase
        send_offset(bad);
        send_offset(good_offset());
        send_data(8'd2);
        send_data(8'hAA);
        settle();
        load_cell(1'b0, 20'd1024, 20'd2, 20'd0);
        repeat (4) send_data(8'($urandom()));
        settle();

        $display("covered %0d requests (%0d decoded), %0d results checked", n_sent,
            n_useful, sb.checked);
        $display("raw and coded cells: %0d columns closed, %0d clipped runs, %0d halts",
            sb.cols_closed, sb.overruns, sb.halts);
        if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
            $display("column_rle_sprite_decoder: match");
        end else begin
            $display("column_rle_sprite_decoder: mismatch");
        end
        $finish;
    end

endmodule
